>>> sv/ntcbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntcbt_pkg
// Shared types, constants and helpers of the NTC beta-equation converter.
// ----------------------------------------------------------------------------
package ntcbt_pkg;

  // Converter sample width and full-scale code.
  localparam int SAMPLE_BITS = 12;
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

  // Configuration register widths and reset values.
  localparam int RES_W  = 20;
  localparam int COEF_W = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = RES_W;
  localparam logic [RES_W-1:0]  FIXED_R_RST   = RES_W'(10000);
  localparam logic [RES_W-1:0]  NOMINAL_R_RST = RES_W'(10000);
  localparam logic [COEF_W-1:0] BETA_RST      = COEF_W'(3950);
  localparam logic [COEF_W-1:0] T0_RST        = COEF_W'(29815);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIXED_R   = 4'd0,
    CFG_NOMINAL_R = 4'd1,
    CFG_BETA      = 4'd2,
    CFG_T0        = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [RES_W-1:0]  fixed_r;
    logic [RES_W-1:0]  nominal_r;
    logic [COEF_W-1:0] beta;
    logic [COEF_W-1:0] t0;
  } cfg_t;

  // Result codes.
  localparam int TEMP_W   = 16;
  localparam int STATUS_W = 2;
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_RAIL = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // Logarithm unit: Q.24 result of an operand below 2^20.
  localparam int LOG_IN_W  = 20;
  localparam int LOG_FRAC  = 24;
  localparam int LOG_LANES = 4;
  localparam int LOG_N_W   = $clog2(LOG_IN_W);
  localparam int LOG_W     = LOG_N_W + LOG_FRAC;
  localparam int MANT_W    = 32;

  // Datapath widths and constants.
  localparam int L2_W   = 32;
  localparam int PROD_W = 64;
  localparam int LN_W   = 32;
  localparam int LN_SHIFT = 30;
  localparam logic signed [L2_W-1:0] LN2_Q30 = 32'sd744261118;
  localparam int DIV_W  = 48;
  localparam int INV_W  = DIV_W + 1;
  localparam logic [DIV_W-1:0] INV_SCALE  = 48'h640000000000;
  localparam logic [DIV_W-1:0] KELVIN_OFS = DIV_W'(27315);
  localparam logic [DIV_W-1:0] TCK_MAX    = DIV_W'(60082);
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7fff;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

  // Sideband flags that travel with an item through the back end.
  typedef struct packed {
    logic rail;
    logic neg;
    logic inv_zero;
    logic inv_neg;
  } tag_t;

  // Classified sample passed from the front end to the back end.
  typedef struct packed {
    logic                   rail;
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] comp;
  } mid_item_t;

  localparam int MID_W  = $bits(mid_item_t);
  localparam int OUT_W  = TEMP_W + STATUS_W;
  localparam int FIFO_W = (MID_W > OUT_W) ? MID_W : OUT_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  function automatic logic [LOG_N_W-1:0] msb_index(input logic [LOG_IN_W-1:0] x);
    logic [LOG_N_W-1:0] n;
    n = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (x[i]) begin
        n = LOG_N_W'(i);
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> sv/ntcbt_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntcbt_fifo
// Small first-in first-out queue; push and pop may coincide, also when full.
// ----------------------------------------------------------------------------
module ntcbt_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [ntcbt_pkg::FIFO_W-1:0] data_i,
  input  logic                        pop_i,
  output logic [ntcbt_pkg::FIFO_W-1:0] data_o,
  output logic                        full_o,
  output logic                        empty_o
);
  import ntcbt_pkg::*;

  logic [FIFO_W-1:0]     mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d;

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign full_o  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule
`default_nettype wire

>>> sv/ntcbt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntcbt_front
// Input stage: takes samples, flags rail readings and forms the divider
// complement, then hands the classified sample to the middle queue.
// ----------------------------------------------------------------------------
module ntcbt_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [ntcbt_pkg::SAMPLE_BITS-1:0] raw_i,
  output logic                             full_o,
  input  logic                             mid_full_i,
  output logic                             mid_push_o,
  output ntcbt_pkg::mid_item_t             mid_item_o
);
  import ntcbt_pkg::*;

  logic      vld_q, vld_d;
  mid_item_t item_q, item_d;
  logic      accept;

  assign full_o     = vld_q && mid_full_i;
  assign accept     = push_i && !full_o;
  assign mid_push_o = vld_q && !mid_full_i;
  assign mid_item_o = item_q;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (mid_push_o) begin
      vld_d = 1'b0;
    end
    item_d.rail = (raw_i == '0) || (raw_i == FULL_SCALE);
    item_d.raw  = raw_i;
    item_d.comp = FULL_SCALE - raw_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/ntcbt_log2.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntcbt_log2
// Pipelined base-2 logarithm, four lanes, Q.24, one squaring per stage.
// ----------------------------------------------------------------------------
module ntcbt_log2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  ntcbt_pkg::tag_t               tag_i,
  input  logic [ntcbt_pkg::LOG_IN_W-1:0] x_i [ntcbt_pkg::LOG_LANES],
  output logic                          vld_o,
  output ntcbt_pkg::tag_t               tag_o,
  output logic [ntcbt_pkg::LOG_W-1:0]    log_o [ntcbt_pkg::LOG_LANES]
);
  import ntcbt_pkg::*;

  logic [LOG_FRAC:0]      vld_q;
  tag_t                   tag_q  [LOG_FRAC+1];
  logic [MANT_W-1:0]      m_q    [LOG_FRAC+1][LOG_LANES];
  logic [LOG_N_W-1:0]     n_q    [LOG_FRAC+1][LOG_LANES];
  logic [LOG_FRAC-1:0]    frac_q [LOG_FRAC+1][LOG_LANES];
  logic [MANT_W-1:0]      m_d    [LOG_FRAC][LOG_LANES];
  logic [LOG_FRAC-1:0]    frac_d [LOG_FRAC][LOG_LANES];
  logic [MANT_W-1:0]      m0_d   [LOG_LANES];
  logic [LOG_N_W-1:0]     n0_d   [LOG_LANES];

  // Normalize so the leading one sits at the top bit of the mantissa.
  always_comb begin
    for (int l = 0; l < LOG_LANES; l++) begin
      n0_d[l] = msb_index(x_i[l]);
      m0_d[l] = MANT_W'(x_i[l]) << (LOG_N_W'(MANT_W-1) - n0_d[l]);
    end
  end

  // Each stage squares the mantissa; a carry past 2.0 yields a result bit.
  always_comb begin : sq_c
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    for (int s = 0; s < LOG_FRAC; s++) begin
      for (int l = 0; l < LOG_LANES; l++) begin
        sq = {{MANT_W{1'b0}}, m_q[s][l]} * {{MANT_W{1'b0}}, m_q[s][l]};
        t  = sq[2*MANT_W-1:MANT_W-1];
        if (t[MANT_W]) begin
          m_d[s][l]    = t[MANT_W:1];
          frac_d[s][l] = frac_q[s][l] | (LOG_FRAC'(1) << (LOG_FRAC-1-s));
        end else begin
          m_d[s][l]    = t[MANT_W-1:0];
          frac_d[s][l] = frac_q[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LOG_FRAC-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      for (int l = 0; l < LOG_LANES; l++) begin
        m_q[0][l]    <= m0_d[l];
        n_q[0][l]    <= n0_d[l];
        frac_q[0][l] <= '0;
      end
      for (int s = 0; s < LOG_FRAC; s++) begin
        tag_q[s+1] <= tag_q[s];
        for (int l = 0; l < LOG_LANES; l++) begin
          m_q[s+1][l]    <= m_d[s][l];
          n_q[s+1][l]    <= n_q[s][l];
          frac_q[s+1][l] <= frac_d[s][l];
        end
      end
    end
  end

  assign vld_o = vld_q[LOG_FRAC];
  assign tag_o = tag_q[LOG_FRAC];
  always_comb begin
    for (int l = 0; l < LOG_LANES; l++) begin
      log_o[l] = {n_q[LOG_FRAC][l], frac_q[LOG_FRAC][l]};
    end
  end

endmodule
`default_nettype wire

>>> sv/ntcbt_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntcbt_div
// Pipelined restoring divider, 48-bit unsigned, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ntcbt_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  ntcbt_pkg::tag_t            tag_i,
  input  logic [ntcbt_pkg::DIV_W-1:0] num_i,
  input  logic [ntcbt_pkg::DIV_W-1:0] den_i,
  output logic                       vld_o,
  output ntcbt_pkg::tag_t            tag_o,
  output logic [ntcbt_pkg::DIV_W-1:0] quo_o
);
  import ntcbt_pkg::*;

  logic [DIV_W:0]   vld_q;
  tag_t             tag_q [DIV_W+1];
  logic [DIV_W-1:0] rem_q [DIV_W+1];
  logic [DIV_W-1:0] quo_q [DIV_W+1];
  logic [DIV_W-1:0] den_q [DIV_W+1];
  logic [DIV_W-1:0] rem_d [DIV_W];
  logic [DIV_W-1:0] quo_d [DIV_W];

  // The quotient register starts as the numerator; its top bit shifts into
  // the remainder while the new quotient bit enters at the bottom.
  always_comb begin : step_c
    logic [DIV_W:0] sh;
    logic [DIV_W:0] diff;
    for (int s = 0; s < DIV_W; s++) begin
      sh   = {rem_q[s], quo_q[s][DIV_W-1]};
      diff = sh - {1'b0, den_q[s]};
      if (sh >= {1'b0, den_q[s]}) begin
        rem_d[s] = diff[DIV_W-1:0];
        quo_d[s] = {quo_q[s][DIV_W-2:0], 1'b1};
      end else begin
        rem_d[s] = sh[DIV_W-1:0];
        quo_d[s] = {quo_q[s][DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_W-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      rem_q[0] <= '0;
      quo_q[0] <= num_i;
      den_q[0] <= den_i;
      for (int s = 0; s < DIV_W; s++) begin
        tag_q[s+1] <= tag_q[s];
        rem_q[s+1] <= rem_d[s];
        quo_q[s+1] <= quo_d[s];
        den_q[s+1] <= den_q[s];
      end
    end
  end

  assign vld_o = vld_q[DIV_W];
  assign tag_o = tag_q[DIV_W];
  assign quo_o = quo_q[DIV_W];

endmodule
`default_nettype wire

>>> sv/ntcbt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntcbt_back
// Conversion pipeline: logarithms, natural-log scaling, 1/T sum and the
// final reciprocal, with rail flagging and saturation into centidegrees Celsius.
// ----------------------------------------------------------------------------
module ntcbt_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ntcbt_pkg::cfg_t                   cfg_i,
  input  logic                              in_vld_i,
  input  ntcbt_pkg::mid_item_t              in_item_i,
  output logic                              in_pop_o,
  input  logic                              out_rdy_i,
  output logic                              out_vld_o,
  output logic signed [ntcbt_pkg::TEMP_W-1:0] out_temp_o,
  output logic [ntcbt_pkg::STATUS_W-1:0]     out_status_o
);
  import ntcbt_pkg::*;

  logic en;
  logic [RES_W-1:0]  fixed_eff, nominal_eff;
  logic [COEF_W-1:0] beta_eff, t0_eff;

  // The whole pipeline advances together whenever the result side has room.
  assign en       = out_rdy_i;
  assign in_pop_o = en && in_vld_i;

  assign fixed_eff   = (cfg_i.fixed_r == '0)   ? RES_W'(1)  : cfg_i.fixed_r;
  assign nominal_eff = (cfg_i.nominal_r == '0) ? RES_W'(1)  : cfg_i.nominal_r;
  assign beta_eff    = (cfg_i.beta == '0)      ? COEF_W'(1) : cfg_i.beta;
  assign t0_eff      = (cfg_i.t0 == '0)        ? COEF_W'(1) : cfg_i.t0;

  // Logarithm stage.
  logic [LOG_IN_W-1:0] log_x [LOG_LANES];
  logic [LOG_W-1:0]    log_r [LOG_LANES];
  tag_t                log_tag_in, log_tag;
  logic                log_vld;

  always_comb begin
    log_x[0] = LOG_IN_W'(fixed_eff);
    log_x[1] = LOG_IN_W'(in_item_i.raw);
    log_x[2] = LOG_IN_W'(in_item_i.comp);
    log_x[3] = LOG_IN_W'(nominal_eff);
    log_tag_in          = '0;
    log_tag_in.rail     = in_item_i.rail;
  end

  ntcbt_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_pop_o),
    .tag_i  (log_tag_in),
    .x_i    (log_x),
    .vld_o  (log_vld),
    .tag_o  (log_tag),
    .log_o  (log_r)
  );

  // Sum of logarithms, scaling by ln 2 and rounding.
  logic                    vld1_q, vld2_q, vld3_q;
  tag_t                    tag1_q, tag2_q, tag3_q, tag3_d;
  logic signed [L2_W-1:0]   l2_q, l2_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [LN_W-1:0]          lnmag_q, lnmag_d;
  logic [PROD_W-1:0]        mag;
  logic [PROD_W-1:0]        mag_r;
  logic                     neg_d;

  always_comb begin
    l2_d = L2_W'(log_r[0]) + L2_W'(log_r[1]) - L2_W'(log_r[2]) - L2_W'(log_r[3]);
    prod_d = l2_q * LN2_Q30;
    neg_d  = prod_q[PROD_W-1];
    mag    = neg_d ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    // Round half away from zero on the magnitude.
    mag_r   = mag + (PROD_W'(1) << (LN_SHIFT-1));
    lnmag_d = mag_r[LN_SHIFT+LN_W-1:LN_SHIFT];
    tag3_d     = tag2_q;
    tag3_d.neg = neg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en) begin
      vld1_q <= log_vld;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag1_q     <= log_tag;
      l2_q       <= l2_d;
      tag2_q     <= tag1_q;
      prod_q     <= prod_d;
      tag3_q     <= tag3_d;
      lnmag_q    <= lnmag_d;
    end
  end

  // Reciprocal of T0 and ln(r/R0)/beta side by side.
  logic [DIV_W-1:0] d0_num, d0_den, d1_num, d1_den, q0, q1;
  logic             dv_vld;
  tag_t             dv_tag;

  assign d0_num = INV_SCALE + DIV_W'(t0_eff >> 1);
  assign d0_den = DIV_W'(t0_eff);
  assign d1_num = {lnmag_q, {(DIV_W-LN_W){1'b0}}} + DIV_W'(beta_eff >> 1);
  assign d1_den = DIV_W'(beta_eff);

  ntcbt_div u_div_t0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld3_q),
    .tag_i  (tag3_q),
    .num_i  (d0_num),
    .den_i  (d0_den),
    .vld_o  (dv_vld),
    .tag_o  (dv_tag),
    .quo_o  (q0)
  );

  ntcbt_div u_div_beta (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld3_q),
    .tag_i  (tag3_q),
    .num_i  (d1_num),
    .den_i  (d1_den),
    .vld_o  (),
    .tag_o  (),
    .quo_o  (q1)
  );

  // 1/T in Q.40 per kelvin.
  logic                    vld4_q;
  tag_t                    tag4_q;
  logic signed [INV_W-1:0] inv_q, inv_d, q0s, q1s;

  always_comb begin
    q0s   = $signed({1'b0, q0});
    q1s   = $signed({1'b0, q1});
    inv_d = dv_tag.neg ? q0s - q1s : q0s + q1s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else if (en) begin
      vld4_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag4_q <= dv_tag;
      inv_q  <= inv_d;
    end
  end

  // Final reciprocal gives T in centikelvin.
  tag_t             fin_tag_in, fin_tag;
  logic [DIV_W-1:0] f_num, f_den, tck;

  always_comb begin
    fin_tag_in          = tag4_q;
    fin_tag_in.inv_zero = (inv_q == '0);
    fin_tag_in.inv_neg  = inv_q[INV_W-1];
    f_num = INV_SCALE + inv_q[DIV_W:1];
    f_den = inv_q[DIV_W-1:0];
  end

  ntcbt_div u_div_t (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld4_q),
    .tag_i  (fin_tag_in),
    .num_i  (f_num),
    .den_i  (f_den),
    .vld_o  (out_vld_o),
    .tag_o  (fin_tag),
    .quo_o  (tck)
  );

  always_comb begin
    if (fin_tag.rail) begin
      out_temp_o   = '0;
      out_status_o = ST_RAIL;
    end else if (fin_tag.inv_zero) begin
      out_temp_o   = TEMP_MAX;
      out_status_o = ST_SAT;
    end else if (fin_tag.inv_neg) begin
      out_temp_o   = TEMP_MIN;
      out_status_o = ST_SAT;
    end else if (tck > TCK_MAX) begin
      out_temp_o   = TEMP_MAX;
      out_status_o = ST_SAT;
    end else begin
      out_temp_o   = TEMP_W'(tck - KELVIN_OFS);
      out_status_o = ST_OK;
    end
  end

endmodule
`default_nettype wire

>>> sv/ntc_beta_temperature_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_beta_temperature_convert
// NTC thermistor temperature converter using the beta equation.
// ----------------------------------------------------------------------------
// The block takes one converter sample per clock cycle while full is low and
// returns one temperature per sample in hundredths of a degree Celsius, in
// order. A request passes a front register, a four-entry queue, a 25-stage
// logarithm pipeline, three scaling stages, and two 49-stage restoring
// dividers with one summing stage between them, one quotient bit per stage.
// The pipeline holds as a whole while the four-entry result queue is full
// and not popped. The user must write configuration registers only while no
// sample is in flight; the block does not enforce this. They take effect
// immediately; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module ntc_beta_temperature_convert (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [ntcbt_pkg::SAMPLE_BITS-1:0]  raw_sample_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [ntcbt_pkg::TEMP_W-1:0] temp_centi_c_o,
  output logic [ntcbt_pkg::STATUS_W-1:0]     status_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ntcbt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ntcbt_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ntcbt_pkg::*;

  // Configuration registers.
  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FIXED_R:   cfg_d.fixed_r   = cfg_data_i;
        CFG_NOMINAL_R: cfg_d.nominal_r = cfg_data_i;
        CFG_BETA:      cfg_d.beta      = cfg_data_i[COEF_W-1:0];
        CFG_T0:        cfg_d.t0        = cfg_data_i[COEF_W-1:0];
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fixed_r   <= FIXED_R_RST;
      cfg_q.nominal_r <= NOMINAL_R_RST;
      cfg_q.beta      <= BETA_RST;
      cfg_q.t0        <= T0_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end and middle queue.
  logic              mid_push, mid_full, mid_empty, mid_pop;
  mid_item_t         mid_in, mid_out;
  logic [FIFO_W-1:0] mid_rd;

  ntcbt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .raw_i      (raw_sample_i),
    .full_o     (full),
    .mid_full_i (mid_full),
    .mid_push_o (mid_push),
    .mid_item_o (mid_in)
  );

  ntcbt_fifo u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (FIFO_W'(mid_in)),
    .pop_i   (mid_pop),
    .data_o  (mid_rd),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  assign mid_out = mid_item_t'(mid_rd[MID_W-1:0]);

  // Back end and result queue.
  logic                     out_rdy, res_vld, res_push;
  logic signed [TEMP_W-1:0] res_temp;
  logic [STATUS_W-1:0]      res_status;
  logic [FIFO_W-1:0]        out_rd;
  logic                     out_full;

  // A pop frees a slot in the same cycle, so a full queue still takes a result.
  assign out_rdy  = !out_full || (pop && !empty);
  assign res_push = res_vld && out_rdy;

  ntcbt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_vld_i     (!mid_empty),
    .in_item_i    (mid_out),
    .in_pop_o     (mid_pop),
    .out_rdy_i    (out_rdy),
    .out_vld_o    (res_vld),
    .out_temp_o   (res_temp),
    .out_status_o (res_status)
  );

  ntcbt_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (FIFO_W'({res_status, res_temp})),
    .pop_i   (pop && !empty),
    .data_o  (out_rd),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign temp_centi_c_o = out_rd[TEMP_W-1:0];
  assign status_o       = out_rd[OUT_W-1:TEMP_W];

endmodule
`default_nettype wire
